// ===== src/i2cms_pkg.sv =====
package i2cms_pkg;

	localparam int unsigned BufferDepthDefault = 128;

	localparam logic [1:0] CMD_STAGE     = 2'd0;
	localparam logic [1:0] CMD_SUB_WRITE = 2'd1;
	localparam logic [1:0] CMD_SUB_READ  = 2'd2;
	localparam logic [1:0] CMD_BUS_EVENT = 2'd3;

	localparam logic [3:0] ACT_NONE   = 4'd0;
	localparam logic [3:0] ACT_START  = 4'd1;
	localparam logic [3:0] ACT_TX     = 4'd2;
	localparam logic [3:0] ACT_RXEN   = 4'd3;
	localparam logic [3:0] ACT_ACK    = 4'd4;
	localparam logic [3:0] ACT_STOP   = 4'd5;
	localparam logic [3:0] ACT_RXDATA = 4'd6;
	localparam logic [3:0] ACT_DONE   = 4'd7;
	localparam logic [3:0] ACT_DROP   = 4'd8;

	typedef struct packed {
		logic [1:0] cmd;
		logic [6:0] address;
		logic [7:0] data_byte;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] bus_byte;
		logic       slot;
		logic       overflow;
		logic       last;
	} res_t;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_STARTED = 6'b000010,
		PH_WDATA   = 6'b000100,
		PH_RWAIT   = 6'b001000,
		PH_RGOT    = 6'b010000,
		PH_STOPPED = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_READ  = 3'b010,
		ST_EMIT2 = 3'b100
	} bst_t;

endpackage

// ===== src/i2cms_fifo.sv =====
module i2cms_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  i2cms_pkg::req_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output i2cms_pkg::req_t   out_data
);
	i2cms_pkg::req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== src/i2cms_engine.sv =====
module i2cms_engine #(
	parameter int unsigned BUFFER_DEPTH = i2cms_pkg::BufferDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  i2cms_pkg::req_t req,
	output logic            res_valid,
	input  logic            res_ready,
	output i2cms_pkg::res_t res
);
	localparam int unsigned AW = $clog2(BUFFER_DEPTH) + 1;
	localparam logic [7:0] Depth = 8'(BUFFER_DEPTH);

	// each slot owns a power-of-two area so {slot, position} always lands inside
	logic [7:0] mem_q [2**AW];
	logic [7:0] rd_q;

	logic [1:0] valid_q, is_wr_q;
	logic [6:0] addr_q [2];
	logic [7:0] len_q [2];
	logic [7:0] pos_q [2];
	logic       serv_v_q, serv_s_q;
	i2cms_pkg::phase_t ph_q;
	logic [7:0] stc_q;
	logic       sts_q;
	i2cms_pkg::bst_t st_q;
	i2cms_pkg::res_t pend_q;

	// output register
	logic out_v_q;
	i2cms_pkg::res_t out_q;
	logic can_out;
	assign can_out = !out_v_q || res_ready;
	assign res_valid = out_v_q;
	assign res = out_q;

	logic s;
	assign s = serv_s_q;

	logic fv_ok, fv;
	assign fv_ok = !(valid_q[0] && valid_q[1]);
	assign fv = valid_q[0];

	// next queued slot after completion of slot s
	logic nx_v, nx_s;
	always_comb begin
		logic [1:0] v;
		v = valid_q;
		v[s] = 1'b0;
		nx_v = v[0] || v[1];
		nx_s = !v[0];
	end

	assign req_ready = (st_q == i2cms_pkg::ST_RUN) && can_out;

	function automatic i2cms_pkg::res_t mk(logic [3:0] a, logic [7:0] b, logic sl,
			logic o, logic l);
		i2cms_pkg::res_t r;
		r.action = a; r.bus_byte = b; r.slot = sl; r.overflow = o; r.last = l;
		return r;
	endfunction

	logic [AW-1:0] widx, ridx;
	logic [7:0] wdat;
	logic wen;

	always_ff @(posedge clk) begin
		if (wen) mem_q[widx] <= wdat;
		rd_q <= mem_q[ridx];
	end

	always_comb begin
		ridx = AW'({s, pos_q[s][AW-2:0]});
		if (AW > 1) ridx = {s, pos_q[s][AW-2:0]};
		wen = 1'b0;
		widx = {sts_q, stc_q[AW-2:0]};
		wdat = req.data_byte;
		if (req_valid && req_ready && req.cmd == i2cms_pkg::CMD_STAGE) begin
			if (stc_q == 8'd0) begin
				wen = fv_ok;
				widx = {fv, {(AW-1){1'b0}}};
			end else wen = (stc_q < Depth);
		end else if (req_valid && req_ready && req.cmd == i2cms_pkg::CMD_BUS_EVENT
				&& serv_v_q && ph_q == i2cms_pkg::PH_RGOT && len_q[s] < Depth) begin
			wen = 1'b1;
			widx = {s, len_q[s][AW-2:0]};
			wdat = req.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; is_wr_q <= '0;
			addr_q <= '{default: '0}; len_q <= '{default: '0}; pos_q <= '{default: '0};
			serv_v_q <= 1'b0; serv_s_q <= 1'b0; ph_q <= i2cms_pkg::PH_IDLE;
			stc_q <= '0; sts_q <= 1'b0; st_q <= i2cms_pkg::ST_RUN;
			out_v_q <= 1'b0; out_q <= '0; pend_q <= '0;
		end else begin
			logic ov;
			ov = out_v_q && !res_ready;
			unique case (st_q)
			i2cms_pkg::ST_EMIT2: if (can_out) begin
				ov = 1'b1; out_q <= pend_q; st_q <= i2cms_pkg::ST_RUN;
			end
			i2cms_pkg::ST_READ: if (can_out) begin
				ov = 1'b1;
				out_q <= mk(i2cms_pkg::ACT_TX, rd_q, s, 1'b0, 1'b1);
				pos_q[s] <= pos_q[s] + 8'd1;
				st_q <= i2cms_pkg::ST_RUN;
			end
			default: if (req_valid && req_ready) begin
				unique case (req.cmd)
				i2cms_pkg::CMD_STAGE: begin
					if (stc_q == 8'd0 && !fv_ok) begin
						ov = 1'b1;
						out_q <= mk(i2cms_pkg::ACT_DROP, 8'd0, 1'b0, 1'b0, 1'b1);
					end else if (stc_q != 8'd0 && stc_q >= Depth) begin
						ov = 1'b1;
						out_q <= mk(i2cms_pkg::ACT_DROP, 8'd0, 1'b0, 1'b1, 1'b1);
					end else begin
						if (stc_q == 8'd0) sts_q <= fv;
						stc_q <= stc_q + 8'd1;
					end
				end
				i2cms_pkg::CMD_SUB_WRITE, i2cms_pkg::CMD_SUB_READ: begin
					logic ok, t, w;
					w = (req.cmd == i2cms_pkg::CMD_SUB_WRITE);
					if (stc_q != 8'd0) begin
						t = w ? sts_q : ~sts_q;
						ok = !valid_q[t];
					end else begin
						t = fv; ok = fv_ok;
					end
					if (!ok) begin
						ov = 1'b1;
						out_q <= mk(i2cms_pkg::ACT_DROP, 8'd0, 1'b0, 1'b0, 1'b1);
					end else begin
						valid_q[t] <= 1'b1;
						is_wr_q[t] <= w;
						addr_q[t] <= req.address;
						pos_q[t] <= 8'd0;
						len_q[t] <= w ? stc_q : 8'd0;
						if (w) stc_q <= 8'd0;
						if (!serv_v_q) begin
							// slot A wins when both are pending
							serv_v_q <= 1'b1;
							serv_s_q <= valid_q[0] ? 1'b0 : t;
							ph_q <= i2cms_pkg::PH_STARTED;
							ov = 1'b1;
							out_q <= mk(i2cms_pkg::ACT_START, 8'd0,
								valid_q[0] ? 1'b0 : t, 1'b0, 1'b1);
						end
					end
				end
				default: if (serv_v_q) begin
					unique case (ph_q)
					i2cms_pkg::PH_STARTED: begin
						ph_q <= is_wr_q[s] ? i2cms_pkg::PH_WDATA : i2cms_pkg::PH_RWAIT;
						ov = 1'b1;
						out_q <= mk(i2cms_pkg::ACT_TX, {addr_q[s], ~is_wr_q[s]}, s,
							1'b0, 1'b1);
					end
					i2cms_pkg::PH_WDATA: begin
						if (pos_q[s] < len_q[s] && pos_q[s] < Depth)
							st_q <= i2cms_pkg::ST_READ;
						else begin
							ph_q <= i2cms_pkg::PH_STOPPED;
							ov = 1'b1;
							out_q <= mk(i2cms_pkg::ACT_STOP, 8'd0, s, 1'b0, 1'b1);
						end
					end
					i2cms_pkg::PH_RWAIT: begin
						ph_q <= i2cms_pkg::PH_RGOT;
						ov = 1'b1;
						out_q <= mk(i2cms_pkg::ACT_RXEN, 8'd0, s, 1'b0, 1'b1);
					end
					i2cms_pkg::PH_RGOT: begin
						logic [7:0] nl;
						nl = (len_q[s] < Depth) ? len_q[s] + 8'd1 : len_q[s];
						len_q[s] <= nl;
						ov = 1'b1;
						out_q <= mk(i2cms_pkg::ACT_RXDATA, req.rx_byte, s, 1'b0, 1'b0);
						st_q <= i2cms_pkg::ST_EMIT2;
						if (req.rx_byte == 8'd0) begin
							ph_q <= i2cms_pkg::PH_STOPPED;
							pend_q <= mk(i2cms_pkg::ACT_STOP, 8'd0, s, 1'b0, 1'b1);
						end else if (nl >= Depth) begin
							ph_q <= i2cms_pkg::PH_STOPPED;
							pend_q <= mk(i2cms_pkg::ACT_STOP, 8'd0, s, 1'b1, 1'b1);
						end else begin
							ph_q <= i2cms_pkg::PH_RWAIT;
							pend_q <= mk(i2cms_pkg::ACT_ACK, 8'd0, s, 1'b0, 1'b1);
						end
					end
					i2cms_pkg::PH_STOPPED: begin
						valid_q[s] <= 1'b0;
						ov = 1'b1;
						out_q <= mk(i2cms_pkg::ACT_DONE, is_wr_q[s] ? pos_q[s] : len_q[s],
							s, 1'b0, !nx_v);
						if (nx_v) begin
							serv_s_q <= nx_s;
							ph_q <= i2cms_pkg::PH_STARTED;
							pend_q <= mk(i2cms_pkg::ACT_START, 8'd0, nx_s, 1'b0, 1'b1);
							st_q <= i2cms_pkg::ST_EMIT2;
						end else begin
							serv_v_q <= 1'b0;
							ph_q <= i2cms_pkg::PH_IDLE;
						end
					end
					default: ;
					endcase
				end
				endcase
			end
			endcase
			out_v_q <= ov;
		end
	end
endmodule

// ===== src/i2c_master_two_slot_sequencer.sv =====
// i2c master sequencer with two request slots
// s_axis: one request per beat; tdata = {rx_byte, data_byte, address, cmd}
// (cmd in the lowest bits). cmd 0 stages a write byte, 1 submits a write,
// 2 submits a read, 3 reports a bus event.
// m_axis: result beats; tdata = {overflow, slot, bus_byte, action},
// tlast marks the final result of one request.
// a two-entry request queue separates the front port from the sequencing
// engine, so requests keep arriving while the engine waits on m_axis.
// the engine takes one request per cycle when it is not busy and its output
// register can take a result; a request causes zero, one or two results,
// each held in an output register, a second one first in a pending register.
// a request with two results, or a bus event that transmits a staged byte
// (payload memory read), holds off the next request with an extra state.
// when m_axis stalls the engine holds and the queue fills, then s_axis
// tready drops. reset clears both slots, the staging count and the queue;
// payload memory is not cleared.
module i2c_master_two_slot_sequencer #(
	parameter int unsigned BUFFER_DEPTH = i2cms_pkg::BufferDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // cmd, address, data_byte, rx_byte, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // action, bus_byte, slot, overflow, zero pad
	output logic        m_axis_tlast
);
	i2cms_pkg::req_t in_req, q_req;
	i2cms_pkg::res_t r;
	logic q_valid, q_ready;

	assign in_req.cmd       = s_axis_tdata[1:0];
	assign in_req.address   = s_axis_tdata[8:2];
	assign in_req.data_byte = s_axis_tdata[16:9];
	assign in_req.rx_byte   = s_axis_tdata[24:17];

	i2cms_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(in_req),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_req)
	);

	i2cms_engine #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
	);

	assign m_axis_tdata = {2'b00, r.overflow, r.slot, r.bus_byte, r.action};
	assign m_axis_tlast = r.last;

`ifndef ASSERT_OFF
	a_act_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3:0] != i2cms_pkg::ACT_NONE &&
			m_axis_tdata[3:0] <= i2cms_pkg::ACT_DROP)) else $error("bad action");
	a_drop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3:0] == i2cms_pkg::ACT_DROP)
			|-> (m_axis_tdata[12] == 1'b0 && m_axis_tlast)) else $error("bad drop");
	a_rxdata_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[3:0] == i2cms_pkg::ACT_RXDATA) |-> !m_axis_tlast)
		else $error("rx data marked last");
`endif
endmodule

// ===== dv/i2c_master_two_slot_sequencer_chk.sv =====
module i2c_master_two_slot_sequencer_chk #(
	parameter int unsigned DEPTH = i2cms_pkg::BufferDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          errors,
	output int          pending
);

	logic       occupied [2];
	logic       is_write [2];
	logic [6:0] target [2];
	int         length [2];
	int         position [2];
	logic [7:0] payload [2*DEPTH];
	logic       busy;
	logic       cur_slot;
	i2cms_pkg::phase_t phase;
	int         staged;
	logic       staged_slot;

	i2cms_pkg::res_t expected_results [$];
	i2cms_pkg::res_t step_out [$];

	initial begin
		errors = 0;
		for (int i = 0; i < 2; i++) begin
			occupied[i] = 0;
			is_write[i] = 0;
			target[i] = '0;
			length[i] = 0;
			position[i] = 0;
		end
		busy = 0;
		cur_slot = 0;
		phase = i2cms_pkg::PH_IDLE;
		staged = 0;
		staged_slot = 0;
	end

	assign pending = expected_results.size();

	task automatic put(logic [3:0] act, logic [7:0] b, logic s, logic ovf);
		i2cms_pkg::res_t r;
		r.action = act;
		r.bus_byte = b;
		r.slot = s;
		r.overflow = ovf;
		r.last = 1'b0;
		step_out.push_back(r);
	endtask

	task automatic serve_next();
		if (busy) return;
		if (occupied[0]) cur_slot = 0;
		else if (occupied[1]) cur_slot = 1;
		else return;
		busy = 1;
		phase = i2cms_pkg::PH_STARTED;
		put(i2cms_pkg::ACT_START, 8'd0, cur_slot, 1'b0);
	endtask

	function automatic int vacant();
		if (!occupied[0]) return 0;
		if (!occupied[1]) return 1;
		return -1;
	endfunction

	task automatic bus_step(logic [7:0] rx);
		logic s;
		s = cur_slot;
		if (!busy) return;
		case (phase)
			i2cms_pkg::PH_STARTED: begin
				phase = is_write[s] ? i2cms_pkg::PH_WDATA : i2cms_pkg::PH_RWAIT;
				put(i2cms_pkg::ACT_TX, {target[s], ~is_write[s]}, s, 1'b0);
			end
			i2cms_pkg::PH_WDATA: begin
				if (position[s] < length[s] && position[s] < DEPTH) begin
					put(i2cms_pkg::ACT_TX, payload[s*DEPTH + position[s]], s, 1'b0);
					position[s]++;
				end else begin
					phase = i2cms_pkg::PH_STOPPED;
					put(i2cms_pkg::ACT_STOP, 8'd0, s, 1'b0);
				end
			end
			i2cms_pkg::PH_RWAIT: begin
				phase = i2cms_pkg::PH_RGOT;
				put(i2cms_pkg::ACT_RXEN, 8'd0, s, 1'b0);
			end
			i2cms_pkg::PH_RGOT: begin
				if (length[s] < DEPTH) begin
					payload[s*DEPTH + length[s]] = rx;
					length[s]++;
				end
				put(i2cms_pkg::ACT_RXDATA, rx, s, 1'b0);
				if (rx == 8'd0) begin
					phase = i2cms_pkg::PH_STOPPED;
					put(i2cms_pkg::ACT_STOP, 8'd0, s, 1'b0);
				end else if (length[s] >= DEPTH) begin
					phase = i2cms_pkg::PH_STOPPED;
					put(i2cms_pkg::ACT_STOP, 8'd0, s, 1'b1);
				end else begin
					phase = i2cms_pkg::PH_RWAIT;
					put(i2cms_pkg::ACT_ACK, 8'd0, s, 1'b0);
				end
			end
			i2cms_pkg::PH_STOPPED: begin
				put(i2cms_pkg::ACT_DONE, 8'(is_write[s] ? position[s] : length[s]), s, 1'b0);
				occupied[s] = 0;
				busy = 0;
				phase = i2cms_pkg::PH_IDLE;
				serve_next();
			end
			default: ;
		endcase
	endtask

	task automatic predict_request(i2cms_pkg::req_t q);
		int s;
		step_out.delete();
		case (q.cmd)
			i2cms_pkg::CMD_STAGE: begin
				s = staged_slot;
				if (staged == 0) s = vacant();
				if (s < 0) put(i2cms_pkg::ACT_DROP, 8'd0, 1'b0, 1'b0);
				else if (staged >= DEPTH) put(i2cms_pkg::ACT_DROP, 8'd0, 1'b0, 1'b1);
				else begin
					staged_slot = s[0];
					payload[s*DEPTH + staged] = q.data_byte;
					staged++;
				end
			end
			i2cms_pkg::CMD_BUS_EVENT: bus_step(q.rx_byte);
			default: begin
				// staged bytes reserve their slot for the next write
				if (staged == 0) s = vacant();
				else if (q.cmd == i2cms_pkg::CMD_SUB_WRITE)
					s = occupied[staged_slot] ? -1 : staged_slot;
				else s = occupied[!staged_slot] ? -1 : int'(!staged_slot);
				if (s < 0) put(i2cms_pkg::ACT_DROP, 8'd0, 1'b0, 1'b0);
				else begin
					occupied[s] = 1;
					is_write[s] = (q.cmd == i2cms_pkg::CMD_SUB_WRITE);
					target[s] = q.address;
					position[s] = 0;
					length[s] = 0;
					if (q.cmd == i2cms_pkg::CMD_SUB_WRITE) begin
						length[s] = staged;
						staged = 0;
					end
					serve_next();
				end
			end
		endcase
		if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
		foreach (step_out[i]) expected_results.push_back(step_out[i]);
	endtask

	always @(posedge clk) begin
		i2cms_pkg::res_t got, want;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			predict_request(i2cms_pkg::req_t'({s_axis_tdata[1:0], s_axis_tdata[8:2],
				s_axis_tdata[16:9], s_axis_tdata[24:17]}));
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tdata[12],
				m_axis_tdata[13], m_axis_tlast};
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: expected act %0d byte %h slot %0d ovf %0d ",
							"last %0d, got act %0d byte %h slot %0d ovf %0d last %0d"},
							want.action, want.bus_byte, want.slot, want.overflow, want.last,
							got.action, got.bus_byte, got.slot, got.overflow, got.last);
				end
			end
		end
	end

endmodule

// ===== dv/i2c_master_two_slot_sequencer_tb.sv =====
module i2c_master_two_slot_sequencer_tb;

	localparam int DEPTH = i2cms_pkg::BufferDepthDefault;
	localparam int LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          errors;
	int          pending;
	int          cycles;
	int          sent;
	int          send_idle_pct;
	int          stall_pct;
	logic        hold_toggle;
	logic        hold_seen;
	int          hold_left;

	i2c_master_two_slot_sequencer #(.BUFFER_DEPTH(DEPTH)) uut (.*);

	i2c_master_two_slot_sequencer_chk #(.DEPTH(DEPTH)) chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver side, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_seen <= 1'b0;
			hold_left <= 0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send(logic [1:0] cmd, logic [6:0] addr, logic [7:0] data, logic [7:0] rx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, rx, data, addr, cmd};
		forever begin
			@(negedge clk);
			if (s_axis_tready) break;
			@(posedge clk);
		end
		@(posedge clk);
		sent++;
	endtask

	task automatic bus(logic [7:0] rx);
		send(i2cms_pkg::CMD_BUS_EVENT, 7'($urandom), 8'($urandom), rx);
	endtask

	// one transfer: staged bytes and a write submit, or a read submit, then bus events
	task automatic transfer();
		int n, events;
		n = ($urandom_range(39) == 0) ? $urandom_range(DEPTH + 2, DEPTH - 2)
			: $urandom_range(6);
		if ($urandom_range(1)) begin
			repeat (n) send(i2cms_pkg::CMD_STAGE, 7'($urandom), 8'($urandom), 8'($urandom));
			send(i2cms_pkg::CMD_SUB_WRITE, 7'($urandom), 8'($urandom), 8'($urandom));
			events = n + $urandom_range(5, 2);
			repeat (events) bus(8'($urandom));
		end else begin
			send(i2cms_pkg::CMD_SUB_READ, 7'($urandom), 8'($urandom), 8'($urandom));
			events = ($urandom_range(29) == 0) ? 2 * DEPTH + 6 : 2 * n + $urandom_range(6, 2);
			repeat (events) bus(($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
		end
	endtask

	initial begin
		int target_items;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		hold_toggle = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		cycles = 0;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every command, drops, bus event while idle
		bus(8'hFF);
		send(i2cms_pkg::CMD_STAGE, 7'd0, 8'hFF, 8'h00);
		send(i2cms_pkg::CMD_STAGE, 7'd0, 8'h00, 8'hFF);
		send(i2cms_pkg::CMD_SUB_WRITE, 7'd127, 8'h00, 8'h00);
		send(i2cms_pkg::CMD_SUB_READ, 7'd0, 8'hFF, 8'hFF);
		send(i2cms_pkg::CMD_SUB_READ, 7'd85, 8'h00, 8'h00);
		send(i2cms_pkg::CMD_STAGE, 7'd0, 8'hA5, 8'h00);
		send(i2cms_pkg::CMD_SUB_WRITE, 7'd42, 8'h00, 8'h00);
		repeat (5) bus(8'h00);
		bus(8'h00);
		bus(8'h00);
		bus(8'hFF);
		bus(8'h00);
		bus(8'h00);
		bus(8'h00);
		bus(8'h00);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 60 : 34) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 60 : 34) : 0;
			target_items = sent + 475;
			if (ph == 0) hold_toggle <= 1'b1;
			while (sent < target_items) begin
				if ($urandom_range(6) == 0)
					send(2'($urandom), 7'($urandom), 8'($urandom), 8'($urandom));
				else
					transfer();
				if (ph == 1 && $urandom_range(30) == 0) begin
					s_axis_tvalid <= 1'b0;
					// sample the count away from the edge the checker updates on
					while (pending != 0) @(negedge clk);
					@(posedge clk);
				end
			end
		end
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
